FILE: hdl/mbps_pkg.sv
// Package for the masked byte pattern search block.
// Holds payload types, configuration register indexes and sizing constants.
// Used by every module under hdl.
package mbps_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int OFFSET_BITS = 32;
    localparam int ADDR_BITS   = 32;
    localparam int LEN_BITS    = 6;
    localparam int CFG_BITS    = 64;
    localparam int IDX_BITS    = 3;
    localparam int WORD_COUNT  = 4;

    localparam logic [IDX_BITS-1:0] CFG_PATTERN_WORD0 = 3'd0;
    localparam logic [IDX_BITS-1:0] CFG_PATTERN_WORD1 = 3'd1;
    localparam logic [IDX_BITS-1:0] CFG_PATTERN_WORD2 = 3'd2;
    localparam logic [IDX_BITS-1:0] CFG_PATTERN_WORD3 = 3'd3;
    localparam logic [IDX_BITS-1:0] CFG_CARE_MASK     = 3'd4;
    localparam logic [IDX_BITS-1:0] CFG_PATTERN_LEN   = 3'd5;
    localparam logic [IDX_BITS-1:0] CFG_BASE_ADDRESS  = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                 found;
        logic [ADDR_BITS-1:0] match_address;
    } out_item_t;

    // Configuration as seen by the datapath: the pattern already reversed
    // so that entry j lines up with the window byte of age j.
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] aligned_pattern;
        logic [MAX_PATTERN-1:0]      aligned_mask;
        logic [LEN_BITS-1:0]         length;
        logic [ADDR_BITS-1:0]        base_address;
    } cfg_view_t;

    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] offset;
    } q_entry_t;

    typedef struct packed {
        logic     push;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: hdl/masked_byte_pattern_search_top.sv
// Top level of the masked byte pattern search block.
// Instantiates mbps_cfg, mbps_front, mbps_queue and mbps_back; depends on mbps_pkg.
//
// The block takes one dump byte per cycle and compares the newest bytes with a
// pattern of up to 32 bytes under a care mask in a single parallel compare. Each
// dump produces exactly one result item: found with the base address plus start
// offset on the first match (a match completed by the final byte counts), or not
// found with address zero when the last byte passes without a match. Bytes after a
// match are ignored until the last byte, which resets the dump state. The deciding
// byte is written into a two-entry queue at the edge that accepts it, and the result
// item then passes from the queue into the output register, which raises valid. A
// stalled consumer does not stop byte intake until the queue fills. The base address
// is added as a result leaves the queue, so configuration may be written only while
// no result item is waiting.
module masked_byte_pattern_search_top
    import mbps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  in_item_t            byte_item,
    output logic                result_valid,
    input  logic                result_stall,
    output out_item_t           result_item,
    input  logic                cfg_en,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    cfg_view_t view;
    q_push_t   push;
    q_entry_t  head;
    q_status_t status;
    logic      pop;
    logic      accept;

    assign byte_stall = status.full;
    assign accept     = byte_valid && !status.full;

    mbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .view      (view)
    );

    mbps_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_item),
        .view   (view),
        .push   (push)
    );

    mbps_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (status)
    );

    mbps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .status       (status),
        .view         (view),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

`ifndef SYNTHESIS
    // The queue must never be written while it is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> !status.full)
        else $error("result queue written while full");

    // The back end only drains an entry that exists.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("result queue read while empty");

    // A not-found result always carries a zero address.
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_item.found) |-> (result_item.match_address == '0))
        else $error("not-found result with nonzero address");

    // A taken queue entry shows up at the output on the next cycle.
    a_pop_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> result_valid)
        else $error("popped entry did not reach the output register");
`endif

endmodule

FILE: hdl/mbps_cfg.sv
// Configuration registers of the masked byte pattern search block.
// Decodes the write port and presents the pattern aligned to the byte window.
// Depends on mbps_pkg.
module mbps_cfg
    import mbps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_en,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    output cfg_view_t           view
);

    logic [WORD_COUNT-1:0][CFG_BITS-1:0] pattern_reg;
    logic [MAX_PATTERN-1:0]              care_reg;
    logic [LEN_BITS-1:0]                 length_reg;
    logic [ADDR_BITS-1:0]                base_reg;

    logic [MAX_PATTERN-1:0][7:0]         pattern_bytes;
    logic [LEN_BITS-1:0]                 eff_length;
    logic [LEN_BITS-1:0]                 sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            care_reg    <= '1;
            length_reg  <= LEN_BITS'(1);
            base_reg    <= '0;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                CFG_PATTERN_WORD0: pattern_reg[0] <= cfg_data;
                CFG_PATTERN_WORD1: pattern_reg[1] <= cfg_data;
                CFG_PATTERN_WORD2: pattern_reg[2] <= cfg_data;
                CFG_PATTERN_WORD3: pattern_reg[3] <= cfg_data;
                CFG_CARE_MASK:     care_reg       <= cfg_data[MAX_PATTERN-1:0];
                CFG_PATTERN_LEN:   length_reg     <= cfg_data[LEN_BITS-1:0];
                CFG_BASE_ADDRESS:  base_reg       <= cfg_data[ADDR_BITS-1:0];
                default:           ;
            endcase
        end
    end

    assign pattern_bytes = pattern_reg;

    // A length of zero acts as one; anything past the window acts as full size.
    always_comb
    begin
        if (length_reg == '0)
            eff_length = LEN_BITS'(1);
        else if (length_reg > LEN_BITS'(MAX_PATTERN))
            eff_length = LEN_BITS'(MAX_PATTERN);
        else
            eff_length = length_reg;
    end

    // Window byte j (j = 0 newest) is compared with pattern byte length-1-j.
    always_comb
    begin
        sel = '0;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            sel = eff_length - LEN_BITS'(1) - LEN_BITS'(j);
            view.aligned_pattern[j] = pattern_bytes[sel[4:0]];
            view.aligned_mask[j]    = (LEN_BITS'(j) < eff_length) && care_reg[sel[4:0]];
        end
        view.length       = eff_length;
        view.base_address = base_reg;
    end

endmodule

FILE: hdl/mbps_front.sv
// Front end of the masked byte pattern search block.
// Keeps the byte window and dump state, compares under the mask and queues results.
// Depends on mbps_pkg.
module mbps_front
    import mbps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_item_t  item,
    input  cfg_view_t view,
    output q_push_t   push
);

    logic [MAX_PATTERN-1:0][7:0] win_reg;
    logic [MAX_PATTERN-1:0][7:0] win_next;
    logic [OFFSET_BITS-1:0]      count_reg;
    logic [OFFSET_BITS-1:0]      count_next;
    logic                        seen_reg;
    logic                        seen_next;

    logic [MAX_PATTERN-1:0]      byte_ok;
    logic [OFFSET_BITS:0]        diff;
    logic                        hit;

    assign win_next = {win_reg[MAX_PATTERN-2:0], item.data_byte};

    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
            byte_ok[j] = !view.aligned_mask[j] || (win_next[j] == view.aligned_pattern[j]);
    end

    // The count saturates so the offset stays meaningful on very long dumps.
    assign count_next = (count_reg == '1) ? count_reg : count_reg + OFFSET_BITS'(1);
    assign diff       = {1'b0, count_next} - (OFFSET_BITS + 1)'(view.length);
    assign hit        = !seen_reg && !diff[OFFSET_BITS] && (&byte_ok);

    always_comb
    begin
        push.push         = accept && (hit || (item.last_byte && !seen_reg));
        push.entry.found  = hit;
        push.entry.offset = diff[OFFSET_BITS-1:0];
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (item.last_byte)
            seen_next = 1'b0;
        else if (hit)
            seen_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else if (accept)
        begin
            seen_reg <= seen_next;
            if (item.last_byte)
                count_reg <= '0;
            else if (!seen_reg)
                count_reg <= count_next;
        end
    end

    // Only bytes of the current dump are ever compared, so the window needs no clear.
    always_ff @(posedge clk)
    begin
        if (accept && !seen_reg)
            win_reg <= win_next;
    end

endmodule

FILE: hdl/mbps_queue.sv
// Two-entry result queue between the front and back of the search block.
// Lets the front keep taking bytes while the back waits on the consumer.
// Depends on mbps_pkg.
module mbps_queue
    import mbps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_push_t   push,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t status
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push.push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push.push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
            slot_reg[wr_ptr_reg] <= push.entry;
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = count_reg == 2'd2;
    assign status.empty = count_reg == 2'd0;

endmodule

FILE: hdl/mbps_back.sv
// Back end of the search block: forms the match address and holds the result item.
// Drains the queue whenever its output register is free or being taken.
// Depends on mbps_pkg.
module mbps_back
    import mbps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_entry_t  head,
    input  q_status_t status,
    input  cfg_view_t view,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;
    out_item_t item_next;

    assign pop        = !status.empty && (!valid_reg || !result_stall);
    assign valid_next = pop || (valid_reg && result_stall);

    always_comb
    begin
        item_next.found         = head.found;
        item_next.match_address = head.found
                                  ? view.base_address + ADDR_BITS'(head.offset)
                                  : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= item_next;
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

endmodule

FILE: sim/masked_byte_pattern_search_top_test.sv
// Self-checking testbench for masked_byte_pattern_search_top.
// Streams dump bytes with random gaps and stalls and checks each result item
// against a built-in model of the masked pattern search. Depends on mbps_pkg.
module masked_byte_pattern_search_top_test;

    import mbps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;
    localparam logic [IDX_BITS-1:0] CFG_SPARE_INDEX = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                byte_valid = 1'b0;
    logic                byte_stall;
    in_item_t            byte_item = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    out_item_t           result_item;
    logic                cfg_en = 1'b0;
    logic [IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    // Model copy of the registers, at their reset values.
    logic [63:0] pat_word [WORD_COUNT] = '{default: '0};
    logic [31:0] care_bits = '1;
    logic [5:0]  pat_len = 6'd1;
    logic [31:0] base_addr = '0;

    // Model copy of the dump state; entry 0 holds the newest byte.
    logic [7:0]  recent_bytes [MAX_PATTERN] = '{default: '0};
    logic [31:0] byte_count = '0;
    logic        match_seen = 1'b0;

    out_item_t pending_results [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 20;
    int        recv_idle_pct = 85;

    masked_byte_pattern_search_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_en       (cfg_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int active_length();
        if (pat_len == 0)
            return 1;
        if (pat_len > MAX_PATTERN)
            return MAX_PATTERN;
        return pat_len;
    endfunction

    function automatic logic [7:0] sig_byte(input int i);
        return pat_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    task automatic apply_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] value);
        case (idx)
            CFG_PATTERN_WORD0: pat_word[0] = value;
            CFG_PATTERN_WORD1: pat_word[1] = value;
            CFG_PATTERN_WORD2: pat_word[2] = value;
            CFG_PATTERN_WORD3: pat_word[3] = value;
            CFG_CARE_MASK:     care_bits = value[31:0];
            CFG_PATTERN_LEN:   pat_len = value[5:0];
            CFG_BASE_ADDRESS:  base_addr = value[31:0];
            default: ;
        endcase
    endtask

    // Shifts one accepted byte into the model window and queues any result it decides.
    task automatic search_step(input in_item_t it);
        int        len;
        logic      hit;
        out_item_t res;
        if (!match_seen)
        begin
            len = active_length();
            for (int k = MAX_PATTERN - 1; k > 0; k--)
                recent_bytes[k] = recent_bytes[k - 1];
            recent_bytes[0] = it.data_byte;
            if (byte_count != '1)
                byte_count++;
            if (byte_count >= len)
            begin
                hit = 1'b1;
                for (int i = 0; i < len; i++)
                    if (care_bits[i] && recent_bytes[len - 1 - i] != sig_byte(i))
                        hit = 1'b0;
                if (hit)
                begin
                    match_seen = 1'b1;
                    res.found = 1'b1;
                    res.match_address = base_addr + (byte_count - 32'(len));
                    pending_results.push_back(res);
                end
            end
        end
        if (it.last_byte)
        begin
            if (!match_seen)
            begin
                res = '0;
                pending_results.push_back(res);
            end
            foreach (recent_bytes[k])
                recent_bytes[k] = '0;
            byte_count = '0;
            match_seen = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string why, input out_item_t want, input out_item_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch (%s): expected found=%0d addr=%h, got found=%0d addr=%h",
                     why, want.found, want.match_address, got.found, got.match_address);
    endtask

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        result_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected result", '0, result_item);
            else
            begin
                want = pending_results.pop_front();
                if (result_item.found !== want.found)
                    flag_mismatch("found", want, result_item);
                else if (result_item.match_address !== want.match_address)
                    flag_mismatch("match_address", want, result_item);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        in_item_t it;
        it.data_byte = value;
        it.last_byte = is_last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item <= it;
        do
            @(posedge clk);
        while (byte_stall);
        search_step(it);
    endtask

    task automatic wait_for_results();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // A byte that decides nothing may still be in the pipeline once the queue is empty.
    task automatic settle_block();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] value);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        apply_reg(idx, value);
    endtask

    // Unused upper data bits carry noise, and the spare index must change nothing.
    task automatic load_settings(input logic [63:0] w0, input logic [63:0] w1,
                                 input logic [63:0] w2, input logic [63:0] w3,
                                 input logic [31:0] mask, input logic [5:0] len,
                                 input logic [31:0] base);
        write_reg(CFG_PATTERN_WORD0, w0);
        write_reg(CFG_PATTERN_WORD1, w1);
        write_reg(CFG_PATTERN_WORD2, w2);
        write_reg(CFG_PATTERN_WORD3, w3);
        write_reg(CFG_CARE_MASK, {$urandom, mask});
        write_reg(CFG_PATTERN_LEN, {$urandom, 26'($urandom), len});
        write_reg(CFG_BASE_ADDRESS, {$urandom, base});
        write_reg(CFG_SPARE_INDEX, {$urandom, $urandom});
        cfg_en <= 1'b0;
        @(posedge clk);
    endtask

    // Builds one dump: mostly a planted pattern in background bytes, some near misses
    // and some pure noise, now and then with a pause until all results are in.
    task automatic run_dump(output int sent);
        logic [7:0] dump_bytes [64];
        int eff;
        int n;
        int at;
        int kind;
        int pos;
        eff = active_length();
        kind = $urandom_range(9);
        if ($urandom_range(9) == 0 && eff > 1)
            n = $urandom_range(eff - 1, 1);
        else
            n = eff + $urandom_range(16);
        foreach (dump_bytes[k])
            dump_bytes[k] = $urandom_range(1) ? 8'($urandom) : sig_byte($urandom_range(eff - 1));
        if (n >= eff && kind < 8)
        begin
            at = (kind == 5 || kind == 6) ? n - eff : $urandom_range(n - eff);
            for (int i = 0; i < eff; i++)
                if (care_bits[i])
                    dump_bytes[at + i] = sig_byte(i);
            if (kind == 7)
            begin
                pos = $urandom_range(eff - 1);
                for (int i = 0; i < eff; i++)
                    if (care_bits[(pos + i) % eff])
                    begin
                        dump_bytes[at + (pos + i) % eff] ^= 8'($urandom_range(255, 1));
                        break;
                    end
            end
        end
        for (int k = 0; k < n; k++)
        begin
            if (k > 0 && $urandom_range(39) == 0)
                wait_for_results();
            send_byte(dump_bytes[k], k == n - 1);
        end
        sent = n;
    endtask

    // Reset values: a one-byte pattern of zero with every position cared for.
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h22, 1'b1);
    endtask

    // Pattern DE ?? BE EF with a base just below the address wrap.
    task automatic test_wildcard_wrap();
        settle_block();
        load_settings(64'h0000_0000_EFBE_00DE, '0, '0, '0, 32'h0000_000D, 6'd4,
                      32'hFFFF_FFFE);
        send_byte(8'h01, 1'b0);
        send_byte(8'hDE, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'h02, 1'b1);
        send_byte(8'hDE, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b1);
        send_byte(8'hDE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEE, 1'b1);
    endtask

    // A length of zero acts as a length of one.
    task automatic test_length_limits();
        settle_block();
        load_settings(64'h0000_0000_0000_00A5, '1, '1, '1, '1, 6'd0, 32'h0000_0100);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    task automatic test_random_dumps(input int first_seg, input int seg_total,
                                     input int bytes_per_seg);
        logic [63:0] w [WORD_COUNT];
        logic [31:0] m;
        logic [31:0] b;
        logic [5:0]  l;
        int sent;
        int done;
        for (int s = first_seg; s < first_seg + seg_total; s++)
        begin
            foreach (w[i])
                w[i] = {$urandom, $urandom};
            case ($urandom_range(7))
                0, 1:    m = '1;
                2, 3:    m = $urandom | $urandom;
                4:       m = '0;
                default: m = $urandom;
            endcase
            case ($urandom_range(7))
                0:       l = 6'd0;
                1:       l = 6'd1;
                2:       l = 6'd32;
                3:       l = 6'($urandom_range(63, 33));
                default: l = 6'($urandom_range(8, 2));
            endcase
            case ($urandom_range(3))
                0:       b = '0;
                1:       b = '1;
                2:       b = 32'hFFFF_FFF0 + 32'($urandom_range(15));
                default: b = $urandom;
            endcase
            // The first segments pin the register extremes.
            if (s == 0)
            begin
                l = 6'd32;
                m = '1;
                b = '1;
            end
            else if (s == 1)
            begin
                l = 6'd63;
                m = '0;
                b = '0;
                foreach (w[i])
                    w[i] = '1;
            end
            else if (s == 2)
                l = 6'd0;
            else if (s == 3)
                foreach (w[i])
                    w[i] = '0;
            settle_block();
            load_settings(w[0], w[1], w[2], w[3], m, l, b);
            done = 0;
            while (done < bytes_per_seg)
            begin
                run_dump(sent);
                done += sent;
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_wildcard_wrap();
        test_length_limits();
        test_random_dumps(0, 4, 125);
        send_idle_pct = 85;
        recv_idle_pct = 20;
        test_random_dumps(4, 4, 125);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_dumps(8, 4, 125);
        settle_block();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
